### rtl/core/ogd_pkg.sv
// Shared types and constants for the page demuxer.
// Used by ogd_lace_ram, ogd_out_reg and ogg_page_demuxer.
package ogd_pkg;

  localparam int unsigned LaceDepth = 255;
  localparam int unsigned LaceAw    = 8;

  localparam logic [7:0]  ContFlag  = 8'h01;
  localparam logic [7:0]  SegFull   = 8'd255;
  localparam logic [4:0]  HdrLast   = 5'd26;
  localparam logic [4:0]  HdrFirst  = 5'd4;
  localparam logic [4:0]  HdrFlags  = 5'd5;
  localparam logic [4:0]  HdrGranLo = 5'd6;
  localparam logic [4:0]  HdrGranHi = 5'd13;
  localparam logic [4:0]  HdrSerLo  = 5'd14;
  localparam logic [4:0]  HdrSerHi  = 5'd17;
  localparam logic [23:0] CapPrefix = 24'h4F6767;  // "Ogg"
  localparam logic [7:0]  CapLast   = 8'h53;       // "S"

  // one lacing table entry: nonzero segment length and ends after it
  typedef struct packed {
    logic [8:0] ends;
    logic [7:0] len;
  } lace_entry_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_ends;
    logic [63:0] granule;
    logic        granule_here;
    logic        dropped_partial;
    logic        truncated;
    logic        stream_done;
  } ogd_result_t;

  // clamp a table position to the last entry
  function automatic logic [LaceAw-1:0] lace_index(input logic [LaceAw:0] pos);
    logic [LaceAw:0] top;
    top = (LaceAw+1)'(LaceDepth - 1);
    lace_index = (pos > top) ? top[LaceAw-1:0] : pos[LaceAw-1:0];
  endfunction

endpackage

### rtl/core/ogd_lace_ram.sv
// Lacing table memory: one write port, one registered read port.
// Depends on ogd_pkg.
module ogd_lace_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ogd_pkg::LaceAw-1:0] waddr,
  input  ogd_pkg::lace_entry_t       wdata,
  input  logic [ogd_pkg::LaceAw-1:0] raddr,
  output ogd_pkg::lace_entry_t       rdata
);

  ogd_pkg::lace_entry_t mem [0:ogd_pkg::LaceDepth-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ogd_out_reg.sv
// Two-entry result buffer between the parser and the output channel.
// Depends on ogd_pkg.
module ogd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ogd_pkg::ogd_result_t din,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ogd_pkg::ogd_result_t dout
);

  ogd_pkg::ogd_result_t skid;
  logic                 skid_valid;
  logic                 drain;

  // room is registered: a stalled output register still takes one more result
  assign room  = !skid_valid;
  assign drain = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      out_valid  <= skid_valid || load;
      skid_valid <= 1'b0;
    end else if (load) begin
      skid_valid <= 1'b1;
    end
    if (drain) begin
      if (skid_valid) dout <= skid;
      else if (load) dout <= din;
    end else if (load) begin
      skid <= din;
    end
  end

endmodule

### rtl/core/ogg_page_demuxer.sv
// Page demuxer: takes one container byte per transaction and returns packet bytes with
// end counts of the first stream found. One byte is accepted per clock while the
// result register drains; each page of the locked stream that has a body passes the idle
// states PH_FLUSH, PH_LOAD0 and PH_LOAD1 between its last lacing byte and its first body
// byte; they complete the lacing table and fetch its first two entries (registered read).
// Depends on ogd_pkg, ogd_lace_ram, ogd_out_reg.
module ogg_page_demuxer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        data_valid,
  output logic [7:0]  payload_byte,
  output logic [7:0]  packet_ends,
  output logic signed [63:0] granule,
  output logic        granule_here,
  output logic        dropped_partial,
  output logic        truncated,
  output logic        stream_done
);

  typedef enum logic [3:0] {
    PH_SEARCH, PH_HEADER, PH_LACE, PH_SKIP_LACE, PH_FLUSH,
    PH_LOAD0, PH_LOAD1, PH_BODY, PH_SKIP_BODY
  } phase_t;

  phase_t      phase, phase_next;
  logic [23:0] recent, recent_next;
  logic [4:0]  hdr_idx, hdr_idx_next;
  logic [7:0]  flags, flags_next;
  logic [63:0] pg_granule, pg_granule_next;
  logic [31:0] serial, serial_next;
  logic [31:0] locked, locked_next;
  logic        is_locked, is_locked_next;
  logic [7:0]  seg_cnt, seg_cnt_next;
  logic [7:0]  pos, pos_next;
  logic [8:0]  leading, leading_next;
  logic [8:0]  total, total_next;
  logic [8:0]  reported, reported_next;
  logic [7:0]  seg_left, seg_left_next;
  logic [16:0] body_left, body_left_next;
  logic        partial, partial_next;
  ogd_pkg::lace_entry_t pend, pend_next;
  logic [8:0]  cur_ends, cur_ends_next;

  logic        room, in_fire, produce, use_ends, accept;
  logic [8:0]  ends_n, rep_sum;
  logic [2:0]  gran_lane;
  logic [1:0]  ser_lane;
  logic        we;
  logic [7:0]  waddr, raddr;
  ogd_pkg::lace_entry_t rd;
  ogd_pkg::ogd_result_t res, res_q;

  assign in_ready = room && (phase != PH_FLUSH) && (phase != PH_LOAD0) && (phase != PH_LOAD1);
  assign in_fire  = in_valid && in_ready;
  assign gran_lane = 3'(hdr_idx - ogd_pkg::HdrGranLo);
  assign ser_lane  = 2'(hdr_idx - ogd_pkg::HdrSerLo);

  always_comb begin
    phase_next = phase;     recent_next = recent;     hdr_idx_next = hdr_idx;
    flags_next = flags;     pg_granule_next = pg_granule; serial_next = serial;
    locked_next = locked;   is_locked_next = is_locked; seg_cnt_next = seg_cnt;
    pos_next = pos;         leading_next = leading;   total_next = total;
    reported_next = reported; seg_left_next = seg_left; body_left_next = body_left;
    partial_next = partial; pend_next = pend;         cur_ends_next = cur_ends;
    res = '0;
    res.granule = '1;
    produce = 1'b0;
    use_ends = 1'b0;
    ends_n = '0;
    rep_sum = '0;
    accept = 1'b0;
    we = 1'b0;
    waddr = ogd_pkg::lace_index({1'b0, pos} - 9'd1);
    raddr = ogd_pkg::lace_index({1'b0, pos} + 9'd1);

    if (in_fire && action) begin
      res.truncated = (phase == PH_LACE) || (phase == PH_BODY) ||
                      (phase == PH_SKIP_LACE) || (phase == PH_SKIP_BODY);
      res.stream_done = 1'b1;
      produce = 1'b1;
      phase_next = PH_SEARCH; recent_next = '0; hdr_idx_next = '0; flags_next = '0;
      pg_granule_next = '0; serial_next = '0; locked_next = '0; is_locked_next = 1'b0;
      seg_cnt_next = '0; pos_next = '0; leading_next = '0; total_next = '0;
      reported_next = '0; seg_left_next = '0; body_left_next = '0; partial_next = 1'b0;
    end else if (in_fire) begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_idx == ogd_pkg::HdrLast) begin
            seg_cnt_next = stream_byte;
            if (!is_locked) begin
              locked_next = serial;
              is_locked_next = 1'b1;
            end
            accept = !is_locked || (serial == locked);
            pos_next = '0; leading_next = '0; total_next = '0;
            reported_next = '0; body_left_next = '0;
            if (accept && ((flags & ogd_pkg::ContFlag) == '0)) begin
              if (partial) begin
                res.dropped_partial = 1'b1;
                produce = 1'b1;
              end
              partial_next = 1'b0;
            end
            if (stream_byte == '0) phase_next = PH_SEARCH;
            else phase_next = accept ? PH_LACE : PH_SKIP_LACE;
          end else begin
            if (hdr_idx == ogd_pkg::HdrFlags) begin
              flags_next = stream_byte;
            end else if (hdr_idx >= ogd_pkg::HdrGranLo && hdr_idx <= ogd_pkg::HdrGranHi) begin
              pg_granule_next[{gran_lane, 3'b000} +: 8] = stream_byte;
            end else if (hdr_idx >= ogd_pkg::HdrSerLo && hdr_idx <= ogd_pkg::HdrSerHi) begin
              serial_next[{ser_lane, 3'b000} +: 8] = stream_byte;
            end
            hdr_idx_next = hdr_idx + 5'd1;
          end
        end
        PH_LACE, PH_SKIP_LACE: begin
          body_left_next = body_left + {9'd0, stream_byte};
          if (phase == PH_LACE) begin
            if (stream_byte != '0) begin
              if (pos != '0) we = 1'b1;  // commit previous entry
              pend_next.len  = stream_byte;
              pend_next.ends = {8'd0, stream_byte != ogd_pkg::SegFull};
              pos_next = pos + 8'd1;
            end else if (pos != '0) begin
              pend_next.ends = pend.ends + 9'd1;
            end else begin
              leading_next = leading + 9'd1;
            end
            if (stream_byte != ogd_pkg::SegFull) total_next = total + 9'd1;
            partial_next = (stream_byte == ogd_pkg::SegFull);
          end
          seg_cnt_next = seg_cnt - 8'd1;
          if (seg_cnt_next == '0) begin
            if (body_left_next == '0) begin
              phase_next = PH_SEARCH;
              use_ends = 1'b1;
            end else if (phase == PH_SKIP_LACE) begin
              phase_next = PH_SKIP_BODY;
            end else begin
              phase_next = PH_FLUSH;
              use_ends = 1'b1;
            end
            ends_n = leading_next;
            if (use_ends && leading_next != '0) produce = 1'b1;
            else use_ends = 1'b0;
          end
        end
        PH_BODY: begin
          res.data_valid = 1'b1;
          res.payload_byte = stream_byte;
          produce = 1'b1;
          seg_left_next = seg_left - 8'd1;
          body_left_next = body_left - 17'd1;
          if (seg_left_next == '0) begin
            use_ends = 1'b1;
            ends_n = cur_ends;
            pos_next = pos + 8'd1;
            raddr = ogd_pkg::lace_index({1'b0, pos} + 9'd2);
            if (body_left_next != '0) begin
              seg_left_next = rd.len;
              cur_ends_next = rd.ends;
            end
          end
          if (body_left_next == '0) phase_next = PH_SEARCH;
        end
        PH_SKIP_BODY: begin
          body_left_next = body_left - 17'd1;
          if (body_left_next == '0) phase_next = PH_SEARCH;
        end
        PH_SEARCH: begin
          if (recent == ogd_pkg::CapPrefix && stream_byte == ogd_pkg::CapLast) begin
            recent_next = '0;
            phase_next = PH_HEADER;
            hdr_idx_next = ogd_pkg::HdrFirst;
            flags_next = '0;
            pg_granule_next = '0;
            serial_next = '0;
          end else begin
            recent_next = {recent[15:0], stream_byte};
          end
        end
        default: ;
      endcase
    end else begin
      unique case (phase)
        PH_FLUSH: begin
          we = 1'b1;
          pos_next = '0;
          phase_next = PH_LOAD0;
        end
        PH_LOAD0: begin
          raddr = '0;
          phase_next = PH_LOAD1;
        end
        PH_LOAD1: begin
          seg_left_next = rd.len;
          cur_ends_next = rd.ends;
          phase_next = PH_BODY;
        end
        default: ;
      endcase
    end

    if (use_ends) begin
      res.packet_ends = ends_n[7:0];
      if (ends_n != '0) begin
        rep_sum = reported + ends_n;
        reported_next = rep_sum;
        if (rep_sum == total_next) begin
          res.granule = pg_granule;
          res.granule_here = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH; recent <= '0; hdr_idx <= '0; flags <= '0;
      pg_granule <= '0; serial <= '0; locked <= '0; is_locked <= 1'b0;
      seg_cnt <= '0; pos <= '0; leading <= '0; total <= '0; reported <= '0;
      seg_left <= '0; body_left <= '0; partial <= 1'b0;
    end else begin
      phase <= phase_next; recent <= recent_next; hdr_idx <= hdr_idx_next;
      flags <= flags_next; pg_granule <= pg_granule_next; serial <= serial_next;
      locked <= locked_next; is_locked <= is_locked_next; seg_cnt <= seg_cnt_next;
      pos <= pos_next; leading <= leading_next; total <= total_next;
      reported <= reported_next; seg_left <= seg_left_next;
      body_left <= body_left_next; partial <= partial_next;
    end
    pend <= pend_next;
    cur_ends <= cur_ends_next;
  end

  ogd_lace_ram u_lace (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (pend),
    .raddr (raddr),
    .rdata (rd)
  );

  ogd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire && produce),
    .din       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_q)
  );

  assign data_valid      = res_q.data_valid;
  assign payload_byte    = res_q.payload_byte;
  assign packet_ends     = res_q.packet_ends;
  assign granule         = res_q.granule;
  assign granule_here    = res_q.granule_here;
  assign dropped_partial = res_q.dropped_partial;
  assign truncated       = res_q.truncated;
  assign stream_done     = res_q.stream_done;

`ifndef SYNTH
  a_eod_resets: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action) |=> (phase == PH_SEARCH && !is_locked))
    else $error("end of data did not return parser to search");

  a_body_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (body_left != '0))
    else $error("body phase with no bytes left");

  a_granule_tag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granule_here) |-> (granule == '1))
    else $error("granule set without granule_here");
`endif

endmodule
